// File: hw/rtl/cbs_pkg.sv
// Shared types and constants for the bit-serial CRC generator/checker.
package cbs_pkg;

    localparam int REM_MAX = 32;
    localparam int LEN_W   = 6;
    localparam int IDX_W   = $clog2(REM_MAX);
    localparam int KEY_W   = 32;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [KEY_W-1:0] KEY_POLY_RST = 32'h04C1_1DB7;
    localparam logic [LEN_W-1:0] KEY_LEN_RST  = LEN_W'(33);

    localparam logic REG_KEY_BITS = 1'b0;
    localparam logic REG_KEY_LEN  = 1'b1;

    localparam logic ACT_GEN   = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    typedef enum logic [1:0] {
        KIND_ECHO    = 2'd0,
        KIND_REM     = 2'd1,
        KIND_VERDICT = 2'd2
    } t_kind;

    typedef struct packed {
        logic action;
        logic data_bit;
        logic frame_end;
    } t_in_item;

    typedef struct packed {
        t_kind out_kind;
        logic  out_bit;
        logic  crc_error;
        logic  run_end;
    } t_out_item;

    // broadcast to every cell of the division register
    typedef struct packed {
        logic step;
        logic clear;
        logic fb;
    } t_cell_ctl;

endpackage

// File: hw/rtl/cbs_cell.sv
// One bit of the CRC division register.
module cbs_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbs_pkg::t_cell_ctl i_ctl,
    input  logic              i_en,
    input  logic              i_poly,
    input  logic              i_shift,
    output logic              o_bit,
    output logic              o_next
);

    logic r_bit;
    logic n_bit;

    // cells above the remainder length stay at zero
    assign o_next = i_en & (i_shift ^ (i_ctl.fb & i_poly));

    always_comb begin
        n_bit = r_bit;
        if (i_ctl.clear) begin
            n_bit = 1'b0;
        end else if (i_ctl.step) begin
            n_bit = o_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// File: hw/rtl/cbs_apb_regs.sv
// APB register file: generator key bits and key length.
module cbs_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbs_pkg::ADDR_W-1:0]    paddr,
    input  logic [cbs_pkg::DATA_W-1:0]    pwdata,
    output logic [cbs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output logic [cbs_pkg::KEY_W-1:0]     o_key_bits,
    output logic [cbs_pkg::LEN_W-1:0]     o_key_len
);

    logic [cbs_pkg::KEY_W-1:0] r_key_bits;
    logic [cbs_pkg::LEN_W-1:0] r_key_len;
    logic                      wr;
    logic                      sel;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign sel    = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bits <= cbs_pkg::KEY_POLY_RST;
            r_key_len  <= cbs_pkg::KEY_LEN_RST;
        end else if (wr) begin
            if (sel == cbs_pkg::REG_KEY_BITS) begin
                r_key_bits <= pwdata[cbs_pkg::KEY_W-1:0];
            end else begin
                r_key_len <= pwdata[cbs_pkg::LEN_W-1:0];
            end
        end
    end

    always_comb begin
        if (sel == cbs_pkg::REG_KEY_LEN) begin
            prdata = {{(cbs_pkg::DATA_W-cbs_pkg::LEN_W){1'b0}}, r_key_len};
        end else begin
            prdata = r_key_bits;
        end
    end

    assign o_key_bits = r_key_bits;
    assign o_key_len  = r_key_len;

endmodule

// File: hw/rtl/crc_bit_serial_gen_check.sv
// Top level: bit-serial CRC generator/checker built on a chain of register cells.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_ready | i_in_item  (t_in_item)
//  out      | output    | o_out_valid/ i_out_ready| o_out_item (t_out_item)
//  config   | input     | psel/penable/pready     | paddr, pwdata, prdata
//
// One input bit per clock while input is not held off: every cell updates in the accept cycle with one XOR.
// A generate frame end is followed by a drain of rem_len remainder bits (key_len-1,
// at most REM_MAX), one per output item, shifted out of the cell chain; input is held off then.
// The output register takes a new result in the cycle the waiting one is taken;
// while a result waits unaccepted, input is held off.
// Reset (synchronous, i_rst_n low) clears the cells, drain counter and output
// valid, and restores the key registers.
module crc_bit_serial_gen_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cbs_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cbs_pkg::t_out_item            o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbs_pkg::ADDR_W-1:0]    paddr,
    input  logic [cbs_pkg::DATA_W-1:0]    pwdata,
    output logic [cbs_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int RM = cbs_pkg::REM_MAX;

    logic [cbs_pkg::KEY_W-1:0] key_bits;
    logic [cbs_pkg::LEN_W-1:0] key_len;
    logic [cbs_pkg::LEN_W-1:0] rem_len;
    logic [cbs_pkg::LEN_W-1:0] len_m1;
    logic [cbs_pkg::IDX_W-1:0] top_idx;

    logic [RM-1:0] rem;
    logic [RM-1:0] rem_next;
    logic [RM-1:0] cell_en;
    logic [RM-1:0] cell_poly;
    logic [RM-1:0] cell_shift;
    logic          top;
    logic          shift0;

    cbs_pkg::t_cell_ctl ctl;

    logic                      r_out_valid;
    cbs_pkg::t_out_item        r_out;
    cbs_pkg::t_out_item        n_out;
    logic [cbs_pkg::LEN_W-1:0] r_drain;
    logic [cbs_pkg::LEN_W-1:0] n_drain;
    logic                      can_load;
    logic                      fire;
    logic                      drain_go;
    logic                      load;

    cbs_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_key_bits (key_bits),
        .o_key_len  (key_len)
    );

    // remainder length: key_len-1, zero for very short keys, saturated at REM_MAX
    assign len_m1 = key_len - cbs_pkg::LEN_W'(1);
    always_comb begin
        if (key_len < cbs_pkg::LEN_W'(2)) begin
            rem_len = '0;
        end else if (len_m1 > cbs_pkg::LEN_W'(RM)) begin
            rem_len = cbs_pkg::LEN_W'(RM);
        end else begin
            rem_len = len_m1;
        end
    end

    assign top_idx = rem_len[cbs_pkg::IDX_W-1:0] - cbs_pkg::IDX_W'(1);
    assign top     = rem[top_idx];

    genvar gi;
    generate
        for (gi = 0; gi < RM; gi++) begin : g_cell
            assign cell_en[gi] = (cbs_pkg::LEN_W'(gi) < rem_len);
            if (gi < cbs_pkg::KEY_W) begin : g_poly
                assign cell_poly[gi] = key_bits[gi];
            end else begin : g_nopoly
                assign cell_poly[gi] = 1'b0;
            end
            if (gi == 0) begin : g_first
                assign cell_shift[gi] = shift0;
            end else begin : g_rest
                assign cell_shift[gi] = rem[gi-1];
            end
            cbs_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_en    (cell_en[gi]),
                .i_poly  (cell_poly[gi]),
                .i_shift (cell_shift[gi]),
                .o_bit   (rem[gi]),
                .o_next  (rem_next[gi])
            );
        end
    endgenerate

    assign can_load   = !r_out_valid || i_out_ready;
    assign o_in_ready = can_load && (r_drain == '0);
    assign fire       = i_in_valid && o_in_ready;
    assign drain_go   = (r_drain != '0) && can_load;

    always_comb begin
        ctl.step  = 1'b0;
        ctl.clear = 1'b0;
        ctl.fb    = 1'b0;
        shift0    = 1'b0;
        n_out     = r_out;
        n_drain   = r_drain;
        load      = 1'b0;
        if (drain_go) begin
            // plain shift toward the top, zero fills in at the bottom
            ctl.step          = 1'b1;
            load              = 1'b1;
            n_out.out_kind    = cbs_pkg::KIND_REM;
            n_out.out_bit     = top;
            n_out.crc_error   = 1'b0;
            n_out.run_end     = (r_drain == cbs_pkg::LEN_W'(1));
            n_drain           = r_drain - cbs_pkg::LEN_W'(1);
        end else if (fire) begin
            ctl.step = 1'b1;
            if (i_in_item.action == cbs_pkg::ACT_CHECK) begin
                ctl.fb = top;
                shift0 = i_in_item.data_bit;
                if (i_in_item.frame_end) begin
                    ctl.clear       = 1'b1;
                    load            = 1'b1;
                    n_out.out_kind  = cbs_pkg::KIND_VERDICT;
                    n_out.out_bit   = 1'b0;
                    n_out.crc_error = |rem_next;
                    n_out.run_end   = 1'b1;
                end
            end else begin
                ctl.fb          = top ^ i_in_item.data_bit;
                load            = 1'b1;
                n_out.out_kind  = cbs_pkg::KIND_ECHO;
                n_out.out_bit   = i_in_item.data_bit;
                n_out.crc_error = 1'b0;
                n_out.run_end   = !i_in_item.frame_end || (rem_len == '0);
                if (i_in_item.frame_end) begin
                    n_drain = rem_len;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_drain     <= '0;
        end else begin
            r_drain <= n_drain;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_check_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (i_in_item.action == cbs_pkg::ACT_CHECK) && i_in_item.frame_end
        |=> (rem == '0))
        else $error("division register not cleared after check frame end");

    a_echo_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (i_in_item.action == cbs_pkg::ACT_GEN)
        |=> o_out_valid && (o_out_item.out_kind == cbs_pkg::KIND_ECHO))
        else $error("generate item did not produce an echo");

    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain <= cbs_pkg::LEN_W'(RM))
        else $error("drain count beyond remainder length");

    a_drain_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain != '0) |-> !o_in_ready)
        else $error("input accepted while remainder drains");

endmodule
